### src/flue_temperature_window_monitor_unit_defines.svh
// Assertion macros for the flue temperature window monitor.
// Included by modules that check their own logic; expects i_clk and i_rst_n in scope.
`ifndef FLUE_TEMPERATURE_WINDOW_MONITOR_UNIT_DEFINES_SVH
`define FLUE_TEMPERATURE_WINDOW_MONITOR_UNIT_DEFINES_SVH

// same-cycle implication
`define FTWM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FTWM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/ftwm_pkg.sv
// Shared types and constants for the flue temperature window monitor.
// No dependencies; imported by the controller, datapath, divider and top level.
`default_nettype none

package ftwm_pkg;

    localparam int unsigned TEMP_W    = 16;
    localparam int unsigned LOSS_W    = 25;
    localparam int unsigned AMB_W     = 14;
    localparam int unsigned COEFA_W   = 15;
    localparam int unsigned COEFB_W   = 10;
    localparam int unsigned O2_W      = 12;
    localparam int unsigned CFG_W     = 15;
    localparam int unsigned CFG_IDX_W = 2;

    // converter scaling: mV = (code * 11000) >> ADC_BITS
    localparam int unsigned MV_W      = 14;
    localparam logic [MV_W-1:0] MV_SCALE = 14'd11000;

    // loss arithmetic widths
    localparam int unsigned DT_W      = TEMP_W + 1;      // signed T - ambient
    localparam int unsigned BD_W      = COEFB_W + O2_W;  // B * d
    localparam int unsigned F_W       = 23;              // A*100 + B*d
    localparam int unsigned PROD_W    = TEMP_W + F_W;    // |dT| * f
    localparam int unsigned DIVR_W    = O2_W + 14;       // d * 10000
    localparam int unsigned DIV_CNT_W = $clog2(PROD_W);

    localparam logic [O2_W-1:0] O2_FULL    = 12'd2100;
    localparam logic [13:0]     LOSS_SCALE = 14'd10000;
    localparam logic [6:0]      A_SCALE    = 7'd100;

    localparam logic [AMB_W-1:0]   AMB_RST   = 14'd2000;
    localparam logic [COEFA_W-1:0] COEFA_RST = 15'd6842;
    localparam logic [COEFB_W-1:0] COEFB_RST = 10'd125;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AMBIENT = 2'd0,
        CFG_COEF_A  = 2'd1,
        CFG_COEF_B  = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_CLEAR  = 1'b1
    } t_op;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic mul;
        logic temp;
        logic fact;
        logic prod;
        logic div_start;
        logic scan;
        logic commit;
        logic out_load;
    } t_ftwm_cmd;

    // datapath -> controller
    typedef struct packed {
        logic scan_done;
        logic div_busy;
        logic out_free;
    } t_ftwm_sts;

endpackage

`default_nettype wire

### src/ftwm_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on ftwm_pkg for operand widths.
`default_nettype none

module ftwm_div
    import ftwm_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [PROD_W-1:0] i_dividend,
    input  wire logic [DIVR_W-1:0] i_divisor,
    output logic                   o_busy,
    output logic [PROD_W-1:0]      o_quotient
);

    logic                 r_busy;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIVR_W-1:0]    r_rem;
    logic [PROD_W-1:0]    r_quo;
    logic [DIVR_W-1:0]    r_dvs;

    logic [DIVR_W:0] trial;
    logic            fits;

    always_comb begin
        trial = {r_rem, r_quo[PROD_W-1]};
        fits  = (trial >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= DIV_CNT_W'(PROD_W - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= DIVR_W'(trial - {1'b0, r_dvs});
            end else begin
                r_rem <= trial[DIVR_W-1:0];
            end
            r_quo <= {r_quo[PROD_W-2:0], fits};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

### src/ftwm_ctrl.sv
// Sequencer for the monitor: steps one transaction through convert, store,
// loss setup, window scan with parallel divide, commit and output. Uses ftwm_pkg.
`default_nettype none

module ftwm_ctrl
    import ftwm_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  wire t_ftwm_sts i_sts,
    output t_ftwm_cmd      o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_TEMP,
        S_FACT,
        S_PROD,
        S_DIVGO,
        S_SCAN,
        S_COMMIT,
        S_OUT
    } t_state;

    t_state r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE:   if (i_valid) r_state <= S_MUL;
                S_MUL:    r_state <= S_TEMP;
                S_TEMP:   r_state <= S_FACT;
                S_FACT:   r_state <= S_PROD;
                S_PROD:   r_state <= S_DIVGO;
                S_DIVGO:  r_state <= S_SCAN;
                S_SCAN:   if (i_sts.scan_done && !i_sts.div_busy) r_state <= S_COMMIT;
                S_COMMIT: r_state <= S_OUT;
                S_OUT:    if (i_sts.out_free) r_state <= S_IDLE;
                default:  r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.load      = (r_state == S_IDLE) && i_valid;
        o_cmd.mul       = (r_state == S_MUL);
        o_cmd.temp      = (r_state == S_TEMP);
        o_cmd.fact      = (r_state == S_FACT);
        o_cmd.prod      = (r_state == S_PROD);
        o_cmd.div_start = (r_state == S_DIVGO);
        o_cmd.scan      = (r_state == S_SCAN);
        o_cmd.commit    = (r_state == S_COMMIT);
        o_cmd.out_load  = (r_state == S_OUT) && i_sts.out_free;
    end

    assign o_ready = (r_state == S_IDLE);

endmodule

`default_nettype wire

### src/ftwm_dp.sv
// Datapath: config registers, temperature conversion, history memory with
// min/max scan, peak and loss arithmetic, output register. Uses ftwm_pkg, ftwm_div.
`default_nettype none

`include "flue_temperature_window_monitor_unit_defines.svh"

module ftwm_dp
    import ftwm_pkg::*;
#(
    parameter int WINDOW_DEPTH = 128,
    parameter int ADC_BITS     = 10
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire logic                 i_operation,
    input  wire logic [ADC_BITS-1:0]  i_adc_code,
    input  wire logic [O2_W-1:0]      i_o2_centi,
    input  wire logic                 i_o2_valid,
    input  wire t_ftwm_cmd            i_cmd,
    output t_ftwm_sts                 o_sts,
    input  wire logic                 i_ready,
    output logic                      o_valid,
    output logic [TEMP_W-1:0]         o_temperature_centi,
    output logic [TEMP_W-1:0]         o_window_min,
    output logic [TEMP_W-1:0]         o_window_max,
    output logic [TEMP_W-1:0]         o_peak_centi,
    output logic signed [LOSS_W-1:0]  o_loss_centi,
    output logic                      o_o2_error
);

    localparam int IDX_W     = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W     = $clog2(WINDOW_DEPTH + 1);
    localparam int MVPROD_W  = ADC_BITS + MV_W;

    // configuration
    logic [AMB_W-1:0]   r_ambient;
    logic [COEFA_W-1:0] r_coef_a;
    logic [COEFB_W-1:0] r_coef_b;

    // latched transaction
    logic                r_op;
    logic [ADC_BITS-1:0] r_code;
    logic [O2_W-1:0]     r_o2;
    logic                r_o2v;

    // working registers
    logic [MVPROD_W-1:0] r_mv_prod;
    logic [O2_W-1:0]     r_d;
    logic                r_loss_en;
    logic                r_err;
    logic [DT_W-1:0]     r_dt;
    logic [BD_W-1:0]     r_bd;
    logic [DIVR_W-1:0]   r_divisor;
    logic [F_W-1:0]      r_f;
    logic [TEMP_W-1:0]   r_dt_mag;
    logic                r_neg;
    logic [PROD_W-1:0]   r_prod;

    // held state
    logic [TEMP_W-1:0]   r_last_temp;
    logic [TEMP_W-1:0]   r_peak;
    logic [LOSS_W-1:0]   r_loss;
    logic [IDX_W-1:0]    r_slot;
    logic [CNT_W-1:0]    r_fill;

    // scan
    logic [TEMP_W-1:0]   mem [WINDOW_DEPTH];
    logic [CNT_W-1:0]    r_rd_addr;
    logic                r_rd_vld;
    logic [TEMP_W-1:0]   r_rd_data;
    logic [TEMP_W-1:0]   r_min;
    logic [TEMP_W-1:0]   r_max;

    // output register
    logic                r_out_vld;
    logic [TEMP_W-1:0]   r_out_temp;
    logic [TEMP_W-1:0]   r_out_min;
    logic [TEMP_W-1:0]   r_out_max;
    logic [TEMP_W-1:0]   r_out_peak;
    logic [LOSS_W-1:0]   r_out_loss;
    logic                r_out_err;

    logic [TEMP_W-1:0]   t_new;
    logic [CNT_W-1:0]    n_fill;
    logic                is_sample;
    logic                mem_we;
    logic                mem_re;
    logic                div_busy;
    logic [PROD_W-1:0]   div_quo;
    logic [LOSS_W-1:0]   quo_mag;
    logic [LOSS_W-1:0]   n_loss;

    always_comb begin
        t_new     = {r_mv_prod[ADC_BITS +: MV_W], 2'b00};
        is_sample = (t_op'(r_op) == OP_SAMPLE);
        n_fill    = r_fill;
        if (is_sample && (r_fill != CNT_W'(WINDOW_DEPTH))) begin
            n_fill = r_fill + 1'b1;
        end
        mem_we  = i_cmd.temp && is_sample;
        mem_re  = i_cmd.scan && (r_rd_addr < r_fill);
        quo_mag = div_quo[LOSS_W-1:0];
        n_loss  = r_neg ? (LOSS_W'(0) - quo_mag) : quo_mag;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ambient <= AMB_RST;
            r_coef_a  <= COEFA_RST;
            r_coef_b  <= COEFB_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_AMBIENT: r_ambient <= i_cfg_data[AMB_W-1:0];
                CFG_COEF_A:  r_coef_a  <= i_cfg_data[COEFA_W-1:0];
                CFG_COEF_B:  r_coef_b  <= i_cfg_data[COEFB_W-1:0];
                default:     ;
            endcase
        end
    end

    // arithmetic pipeline, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_operation;
            r_code <= i_adc_code;
            r_o2   <= i_o2_centi;
            r_o2v  <= i_o2_valid;
        end
        if (i_cmd.mul) begin
            r_mv_prod <= MVPROD_W'(r_code) * MVPROD_W'(MV_SCALE);
            r_d       <= O2_FULL - r_o2;
            r_loss_en <= is_sample && r_o2v && (r_o2 < O2_FULL);
            r_err     <= is_sample && r_o2v && (r_o2 >= O2_FULL);
        end
        if (i_cmd.temp) begin
            r_dt      <= {1'b0, t_new} - DT_W'(r_ambient);
            r_bd      <= BD_W'(r_coef_b) * BD_W'(r_d);
            r_divisor <= DIVR_W'(r_d) * DIVR_W'(LOSS_SCALE);
        end
        if (i_cmd.fact) begin
            r_f      <= F_W'(r_coef_a) * F_W'(A_SCALE) + F_W'(r_bd);
            r_neg    <= r_dt[DT_W-1];
            r_dt_mag <= r_dt[DT_W-1] ? TEMP_W'(DT_W'(0) - r_dt) : r_dt[TEMP_W-1:0];
        end
        if (i_cmd.prod) begin
            r_prod <= PROD_W'(r_dt_mag) * PROD_W'(r_f);
        end
    end

    // held state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_temp <= '0;
            r_peak      <= '0;
            r_loss      <= '0;
            r_slot      <= '0;
            r_fill      <= '0;
        end else begin
            if (i_cmd.temp) begin
                if (is_sample) begin
                    r_last_temp <= t_new;
                    if (t_new > r_peak) begin
                        r_peak <= t_new;
                    end
                    if (r_slot == IDX_W'(WINDOW_DEPTH - 1)) begin
                        r_slot <= '0;
                    end else begin
                        r_slot <= r_slot + 1'b1;
                    end
                    r_fill <= n_fill;
                end else begin
                    r_peak <= '0;
                end
            end
            if (i_cmd.commit && r_loss_en) begin
                r_loss <= n_loss;
            end
        end
    end

    // history memory; entries at or above the fill count are never written and are not read by the scan
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_slot] <= t_new;
        end
        if (mem_re) begin
            r_rd_data <= mem[r_rd_addr[IDX_W-1:0]];
        end
    end

    // window scan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_addr <= '0;
            r_rd_vld  <= 1'b0;
        end else if (i_cmd.temp) begin
            r_rd_addr <= '0;
            r_rd_vld  <= 1'b0;
        end else if (i_cmd.scan) begin
            r_rd_vld <= mem_re;
            if (mem_re) begin
                r_rd_addr <= r_rd_addr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.temp) begin
            // min starts at zero until the window is full, as if unwritten entries read as zero
            r_min <= (n_fill == CNT_W'(WINDOW_DEPTH)) ? '1 : '0;
            r_max <= '0;
        end else if (i_cmd.scan && r_rd_vld) begin
            if (r_rd_data < r_min) r_min <= r_rd_data;
            if (r_rd_data > r_max) r_max <= r_rd_data;
        end
    end

    ftwm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_prod),
        .i_divisor  (r_divisor),
        .o_busy     (div_busy),
        .o_quotient (div_quo)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_temp <= r_last_temp;
            r_out_min  <= r_min;
            r_out_max  <= r_max;
            r_out_peak <= r_peak;
            r_out_loss <= r_loss;
            r_out_err  <= r_err;
        end
    end

    always_comb begin
        o_sts.scan_done = !r_rd_vld && (r_rd_addr == r_fill);
        o_sts.div_busy  = div_busy;
        o_sts.out_free  = !r_out_vld || i_ready;
    end

    assign o_valid             = r_out_vld;
    assign o_temperature_centi = r_out_temp;
    assign o_window_min        = r_out_min;
    assign o_window_max        = r_out_max;
    assign o_peak_centi        = r_out_peak;
    assign o_loss_centi        = r_out_loss;
    assign o_o2_error          = r_out_err;

    `FTWM_ASSERT_IMP(a_scan_in_range, i_cmd.scan, r_rd_addr <= r_fill, "scan address past fill count")
    `FTWM_ASSERT_IMP(a_commit_div_done, i_cmd.commit, !div_busy, "loss committed while divider busy")
    `FTWM_ASSERT_IMP(a_commit_order, i_cmd.commit, r_min <= r_max, "window min above max")
    `FTWM_ASSERT_IMP(a_out_no_overwrite, i_cmd.out_load, !r_out_vld || i_ready, "pending result overwritten")
    `FTWM_ASSERT_NXT(a_div_starts, i_cmd.div_start, div_busy, "divider did not start")

endmodule

`default_nettype wire

### src/flue_temperature_window_monitor_unit.sv
// Flue temperature window monitor: the min/max scan and the divider run side by side, and the
// result is loaded once both are done; a new transaction is taken the cycle after the result
// is loaded, so the monitor does not take a new sample before the last one is through. The
// min/max scan reads one history entry per cycle from the history memory and sets the rate
// once the window is full, unless the divider is the longer of the two.
// Synchronous active-low reset: history reads as zero (fill count), config back to defaults.
`default_nettype none

module flue_temperature_window_monitor_unit
    import ftwm_pkg::*;
#(
    parameter int WINDOW_DEPTH = 128,
    parameter int ADC_BITS     = 10
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic                 i_operation,
    input  wire logic [ADC_BITS-1:0]  i_adc_code,
    input  wire logic [O2_W-1:0]      i_o2_centi,
    input  wire logic                 i_o2_valid,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [TEMP_W-1:0]         o_temperature_centi,
    output logic [TEMP_W-1:0]         o_window_min,
    output logic [TEMP_W-1:0]         o_window_max,
    output logic [TEMP_W-1:0]         o_peak_centi,
    output logic signed [LOSS_W-1:0]  o_loss_centi,
    output logic                      o_o2_error
);

    t_ftwm_cmd cmd;
    t_ftwm_sts sts;

    ftwm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    ftwm_dp #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .ADC_BITS     (ADC_BITS)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_data          (i_cfg_data),
        .i_operation         (i_operation),
        .i_adc_code          (i_adc_code),
        .i_o2_centi          (i_o2_centi),
        .i_o2_valid          (i_o2_valid),
        .i_cmd               (cmd),
        .o_sts               (sts),
        .i_ready             (i_ready),
        .o_valid             (o_valid),
        .o_temperature_centi (o_temperature_centi),
        .o_window_min        (o_window_min),
        .o_window_max        (o_window_max),
        .o_peak_centi        (o_peak_centi),
        .o_loss_centi        (o_loss_centi),
        .o_o2_error          (o_o2_error)
    );

endmodule

`default_nettype wire
